// ----- rtl/core/lttc_pkg.sv -----
`timescale 1ns / 1ps

package lttc_pkg;

	// Request and result payloads
	typedef struct packed {
		logic [15:0] beam_range;
		logic        scan_end;
	} in_item_t;

	typedef struct packed {
		logic        beam_brake;
		logic [15:0] beam_ttc;
		logic        scan_done;
		logic [15:0] scan_min_ttc;
		logic        scan_brake;
	} out_item_t;

	// Register map, indexed by paddr[2]
	localparam int unsigned REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_SPEED  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_THRESH = 1'b1;

	localparam logic [15:0] THRESH_RESET = 16'd179;
	localparam logic [15:0] TTC_MAX      = 16'hFFFF;

	// One quotient bit per divider step
	localparam int unsigned DIV_STEPS = 16;

	localparam logic [63:0] TWO_PI_URAD  = 64'd6283185;
	localparam logic [63:0] PI_URAD      = 64'd3141593;
	localparam logic [63:0] HALF_PI_URAD = 64'd1570796;

	// Cosine of idx * step microradians, signed Q1.14, by a six-term Taylor series
	// in Q30. Evaluated at elaboration only.
	function automatic logic signed [15:0] cos_q14(input int unsigned idx,
		input int unsigned step);
		logic [63:0]        a;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        mag;
		logic signed [63:0] sum;
		logic               neg;
		a = (64'(idx) * 64'(step)) % TWO_PI_URAD;
		neg = 1'b0;
		if (a > PI_URAD) begin
			a = TWO_PI_URAD - a;
		end
		if (a > HALF_PI_URAD) begin
			a = PI_URAD - a;
			neg = 1'b1;
		end
		x = (a << 30) / 64'd1000000;
		x2 = (x * x) >> 30;
		sum = 64'sd1 << 30;
		term = 64'd1 << 30;
		for (int k = 1; k <= 5; k++) begin
			term = (term * x2) >> 30;
			case (k)
				1: term = term / 64'd2;
				2: term = term / 64'd12;
				3: term = term / 64'd30;
				4: term = term / 64'd56;
				default: term = term / 64'd90;
			endcase
			if ((k % 2) == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 64'sd0;
		end
		mag = ($unsigned(sum) + 64'd32768) >> 16;
		return neg ? -$signed(16'(mag)) : $signed(16'(mag));
	endfunction

endpackage

// ----- rtl/core/lttc_cos_rom.sv -----
`timescale 1ns / 1ps

module lttc_cos_rom
	import lttc_pkg::*;
#(
	parameter int unsigned NUM_BEAMS           = 1080,
	parameter int unsigned ANGLE_STEP_MICRORAD = 4363,
	localparam int unsigned IDX_W              = $clog2(NUM_BEAMS)
) (
	input  logic                    clk,
	input  logic                    rd_en,
	input  logic [IDX_W-1:0]        rd_idx,
	output logic signed [15:0]      cos_q
);

	logic signed [15:0] rom_w [NUM_BEAMS];

	// Fold the table in at elaboration, one entry per beam
	for (genvar g = 0; g < NUM_BEAMS; g++) begin : g_rom
		assign rom_w[g] = cos_q14(g, ANGLE_STEP_MICRORAD);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cos_q <= rom_w[rd_idx];
		end
	end

endmodule

// ----- rtl/core/lttc_serial_div.sv -----
`timescale 1ns / 1ps

module lttc_serial_div
	import lttc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        dividend,
	input  logic signed [31:0] divisor,
	output logic               done,
	output logic [15:0]        quotient
);

	localparam int unsigned CNT_W = $clog2(DIV_STEPS);

	logic             active_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [29:0]      rem_q;
	logic [29:0]      dvs_q;
	logic [15:0]      quo_q;

	logic [29:0] top_w;
	logic        sat_w;
	logic [31:0] diff_w;
	logic        qbit_w;

	// Dividend is range << 26; its upper part range << 10 sets overflow
	assign top_w  = {4'b0, dividend, 10'b0};
	assign sat_w  = divisor[31] || (divisor == 32'sd0) || (top_w >= divisor[29:0]);
	assign diff_w = {1'b0, rem_q, 1'b0} - {2'b0, dvs_q};
	assign qbit_w = !diff_w[31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (sat_w) begin
					done_q <= 1'b1;
				end else begin
					active_q <= 1'b1;
				end
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= top_w;
			dvs_q <= divisor[29:0];
			quo_q <= sat_w ? TTC_MAX : '0;
		end else if (active_q) begin
			rem_q <= qbit_w ? diff_w[29:0] : {rem_q[28:0], 1'b0};
			quo_q <= {quo_q[14:0], qbit_w};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |-> !active_q)
		else $error("divider restarted while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && (cnt_q == CNT_W'(DIV_STEPS - 1))) |=> (done_q && !active_q))
		else $error("divider missed its last step");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !active_q)
		else $error("divider done while still stepping");

endmodule

// ----- rtl/core/lidar_time_to_collision_brake.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | in_item  (beam_range, scan_end)
// out     | output    | out_valid/out_ready| out_item (beam_brake, beam_ttc, scan_done,
//         |           |                    |           scan_min_ttc, scan_brake)
// cfg     | input     | APB, pready = 1    | paddr[2]: 0 vehicle_speed, 1 brake_threshold
//
// An item goes from acceptance to its result through these steps: cosine ROM read at
// acceptance, one multiply, one divider load, 16 restoring division steps, taking the
// quotient, loading the result. The next request is taken once the FSM is back in idle.
// A zero, opening or overflowing rate skips the division steps.
// Reset initialises the FSM, beam counter, scan min/any-brake, output valid and config registers.
// The next request is taken while a result waits in the output register; a
// finished beam waits in the result state until that register frees up.

module lidar_time_to_collision_brake
	import lttc_pkg::*;
#(
	parameter int unsigned NUM_BEAMS           = 1080,
	parameter int unsigned ANGLE_STEP_MICRORAD = 4363
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,

	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned IDX_W = $clog2(NUM_BEAMS);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_START = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic signed [15:0] speed_q;
	logic [15:0]        thresh_q;

	// Scan state
	logic [IDX_W-1:0]   beam_cnt_q;
	logic [15:0]        run_min_q;
	logic               any_brake_q;

	// Per-beam working registers
	logic [15:0]        range_q;
	logic               last_q;
	logic [15:0]        ttc_q;
	logic signed [15:0] cos_w;
	logic signed [31:0] mul_w;
	logic signed [31:0] rate_s1;

	logic               div_done;
	logic [15:0]        div_quo;

	logic               out_valid_q;
	out_item_t          out_item_q;

	logic               in_fire;
	logic               cfg_wr;
	logic               slot_free;
	logic               beam_brake_w;
	logic [15:0]        new_min_w;
	logic               new_any_w;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_wr    = psel && penable && pwrite;
	assign pready    = 1'b1;
	assign slot_free = !out_valid_q || out_ready;

	// Config write and readback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q  <= '0;
			thresh_q <= THRESH_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_SPEED:  speed_q  <= pwdata[15:0];
				REG_THRESH: thresh_q <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SPEED:  prdata = {16'b0, speed_q};
			REG_THRESH: prdata = {16'b0, thresh_q};
		endcase
	end

	// Cosine for the current beam, read on acceptance
	lttc_cos_rom #(
		.NUM_BEAMS           (NUM_BEAMS),
		.ANGLE_STEP_MICRORAD (ANGLE_STEP_MICRORAD)
	) u_rom (
		.clk    (clk),
		.rd_en  (in_fire),
		.rd_idx (beam_cnt_q),
		.cos_q  (cos_w)
	);

	// Closing rate, Q5.26: positive when the target approaches
	assign mul_w = speed_q * cos_w;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			rate_s1 <= -mul_w;
		end
	end

	lttc_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_START),
		.dividend (range_q),
		.divisor  (rate_s1),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Scan bookkeeping for the finished beam
	assign beam_brake_w = (ttc_q < thresh_q);
	assign new_min_w    = (ttc_q < run_min_q) ? ttc_q : run_min_q;
	assign new_any_w    = any_brake_q || beam_brake_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			beam_cnt_q  <= '0;
			run_min_q   <= TTC_MAX;
			any_brake_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load a finished beam, else drop the result once it is taken
			if ((state_q == ST_DONE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						// advance the beam index; a scan end or the last beam wraps it
						if (in_item.scan_end || (beam_cnt_q == IDX_W'(NUM_BEAMS - 1))) begin
							beam_cnt_q <= '0;
						end else begin
							beam_cnt_q <= beam_cnt_q + 1'b1;
						end
						state_q <= ST_MUL;
					end
				end
				ST_MUL:   state_q <= ST_START;
				ST_START: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold the beam until the output register is free
					if (slot_free) begin
						run_min_q   <= last_q ? TTC_MAX : new_min_w;
						any_brake_q <= last_q ? 1'b0 : new_any_w;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			range_q <= in_item.beam_range;
			last_q  <= in_item.scan_end;
		end
		if ((state_q == ST_DIV) && div_done) begin
			ttc_q <= div_quo;
		end
		if ((state_q == ST_DONE) && slot_free) begin
			out_item_q.beam_brake   <= beam_brake_w;
			out_item_q.beam_ttc     <= ttc_q;
			out_item_q.scan_done    <= last_q;
			out_item_q.scan_min_ttc <= last_q ? new_min_w : 16'h0000;
			out_item_q.scan_brake   <= last_q && new_any_w;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assert property (@(posedge clk) disable iff (!arst_n) in_fire |=> (state_q == ST_MUL))
		else $error("accepted request did not enter the multiply cycle");
	assert property (@(posedge clk) disable iff (!arst_n) div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_item.scan_done) |->
		((out_item.scan_min_ttc == 16'h0000) && !out_item.scan_brake))
		else $error("scan summary set on a beam that does not end the scan");

endmodule

// ----- bench/ttc_checker.sv -----
`timescale 1ns / 1ps

module ttc_checker
	import lttc_pkg::*;
#(
	parameter int unsigned NUM_BEAMS           = 1080,
	parameter int unsigned ANGLE_STEP_MICRORAD = 4363
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	input  logic        in_ready,
	input  in_item_t    in_item,

	input  logic        out_valid,
	input  logic        out_ready,
	input  out_item_t   out_item,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,

	output int unsigned failures,
	output int unsigned beams_in_flight
);

	localparam longint unsigned FULL_TURN_URAD    = 64'd6283185;
	localparam longint unsigned HALF_TURN_URAD    = 64'd3141593;
	localparam longint unsigned QUARTER_TURN_URAD = 64'd1570796;
	localparam logic [15:0]     TTC_SATURATED     = 16'hFFFF;
	localparam logic [15:0]     LIMIT_AT_RESET    = 16'd179;
	localparam int unsigned     REPORT_LIMIT      = 10;

	logic signed [15:0] speed_q12;
	logic [15:0]        brake_limit;
	logic [10:0]        beam_idx;
	logic [15:0]        scan_min;
	logic               scan_braked;
	out_item_t          expected_beams[$];

	// Cosine of the beam angle in signed Q1.14: fold into the first quadrant,
	// then a six-term series in Q30 radians.
	function automatic longint beam_cosine(input logic [10:0] beam);
		longint unsigned angle;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned mag;
		longint          acc;
		bit              flip;
		angle = (64'(beam) * 64'(ANGLE_STEP_MICRORAD)) % FULL_TURN_URAD;
		flip = 1'b0;
		if (angle > HALF_TURN_URAD) begin
			angle = FULL_TURN_URAD - angle;
		end
		if (angle > QUARTER_TURN_URAD) begin
			angle = HALF_TURN_URAD - angle;
			flip = 1'b1;
		end
		x = (angle << 30) / 64'd1000000;
		x2 = (x * x) >> 30;
		acc = 64'sd1 << 30;
		term = 64'd1 << 30;
		for (int k = 1; k <= 5; k++) begin
			term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
			if ((k % 2) == 1) begin
				acc = acc - $signed(term);
			end else begin
				acc = acc + $signed(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		mag = ($unsigned(acc) + 64'd32768) >> 16;
		return flip ? -$signed(mag) : $signed(mag);
	endfunction

	// Work out one beam's result and advance the scan state.
	function automatic out_item_t predict_beam(input in_item_t req);
		out_item_t       res;
		longint          rate;
		longint unsigned quot;
		logic [15:0]     ttc;
		rate = -(longint'(speed_q12) * beam_cosine(beam_idx));
		if (rate <= 0) begin
			ttc = TTC_SATURATED;
		end else begin
			quot = (64'(req.beam_range) << 26) / $unsigned(rate);
			ttc = (quot > 64'(TTC_SATURATED)) ? TTC_SATURATED : quot[15:0];
		end
		res.beam_brake = (ttc < brake_limit);
		res.beam_ttc = ttc;
		if (ttc < scan_min) begin
			scan_min = ttc;
		end
		scan_braked = scan_braked | res.beam_brake;
		res.scan_done = req.scan_end;
		res.scan_min_ttc = req.scan_end ? scan_min : 16'd0;
		res.scan_brake = req.scan_end ? scan_braked : 1'b0;
		if (req.scan_end) begin
			beam_idx = '0;
			scan_min = '1;
			scan_braked = 1'b0;
		end else begin
			beam_idx = beam_idx + 1'b1;
			if (beam_idx >= NUM_BEAMS) begin
				beam_idx = '0;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			speed_q12 = '0;
			brake_limit = LIMIT_AT_RESET;
			beam_idx = '0;
			scan_min = '1;
			scan_braked = 1'b0;
			expected_beams.delete();
			failures = 0;
			beams_in_flight = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_beams.size() == 0) begin
					failures++;
					if (failures <= REPORT_LIMIT) begin
						$display("unexpected beam result: brake=%0d ttc=%0d done=%0d min=%0d any=%0d",
							out_item.beam_brake, out_item.beam_ttc, out_item.scan_done,
							out_item.scan_min_ttc, out_item.scan_brake);
					end
				end else begin
					want = expected_beams.pop_front();
					if (want.beam_brake !== out_item.beam_brake ||
						want.beam_ttc !== out_item.beam_ttc ||
						want.scan_done !== out_item.scan_done ||
						want.scan_min_ttc !== out_item.scan_min_ttc ||
						want.scan_brake !== out_item.scan_brake) begin
						failures++;
						if (failures <= REPORT_LIMIT) begin
							$display("beam mismatch at %0t: expected brake=%0d ttc=%0d done=%0d min=%0d any=%0d",
								$realtime, want.beam_brake, want.beam_ttc, want.scan_done,
								want.scan_min_ttc, want.scan_brake);
							$display("                      got brake=%0d ttc=%0d done=%0d min=%0d any=%0d",
								out_item.beam_brake, out_item.beam_ttc, out_item.scan_done,
								out_item.scan_min_ttc, out_item.scan_brake);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_beams.push_back(predict_beam(in_item));
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[2 +: REG_IDX_W])
					REG_SPEED: begin
						speed_q12 = pwdata[15:0];
					end
					REG_THRESH: begin
						brake_limit = pwdata[15:0];
					end
					default: begin
					end
				endcase
			end
			beams_in_flight = expected_beams.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import lttc_pkg::*;

	localparam int unsigned BEAMS_PER_SCAN = 1080;
	localparam int unsigned BEAM_STEP_URAD = 4363;
	localparam logic [2:0]  SPEED_ADDR     = {REG_SPEED, 2'b00};
	localparam logic [2:0]  THRESH_ADDR    = {REG_THRESH, 2'b00};
	// Slack to run on after the last result has come back
	localparam int unsigned SETTLE_CYCLES  = 40;
	localparam int unsigned RESET_CYCLES   = 11;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_item;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned failures;
	int unsigned beams_in_flight;

	// Percent of cycles in which the sender holds off and the receiver stalls
	int unsigned send_idle_pct;
	int unsigned sink_stall_pct;

	lidar_time_to_collision_brake #(
		.NUM_BEAMS          (BEAMS_PER_SCAN),
		.ANGLE_STEP_MICRORAD(BEAM_STEP_URAD)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Watch both channels and the register port, predict and compare
	ttc_checker #(
		.NUM_BEAMS          (BEAMS_PER_SCAN),
		.ANGLE_STEP_MICRORAD(BEAM_STEP_URAD)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_item        (in_item),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_item       (out_item),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.failures       (failures),
		.beams_in_flight(beams_in_flight)
	);

	always #6 clk = ~clk;

	// Stall the result channel at random; a zero percentage keeps it always ready
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Offer one beam request and hold it until the block takes it. Valid is only
	// dropped when a hold-off is drawn, so back-to-back requests keep it high.
	task automatic send_beam(input logic [15:0] range_q8, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) begin
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_item  <= '{beam_range: range_q8, scan_end: last};
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (beams_in_flight != 0) begin
			@(posedge clk);
		end
	endtask

	// One APB write; psel stays high so a second write can follow directly
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
	endtask

	// Reprogram speed and threshold once the block has gone quiet. The upper
	// half of the data bus carries junk that the block must ignore.
	task automatic program_settings(input logic [15:0] speed_q12, input logic [15:0] limit_q8);
		wait_idle();
		write_reg(SPEED_ADDR, {16'($urandom), speed_q12});
		write_reg(THRESH_ADDR, {16'($urandom), limit_q8});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Ranges lean toward the extremes and toward short distances, which give
	// times near the usual thresholds
	function automatic logic [15:0] pick_range();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10) begin
			return 16'd0;
		end
		if (pick < 20) begin
			return 16'hFFFF;
		end
		if (pick < 50) begin
			return 16'($urandom_range(2047));
		end
		return 16'($urandom);
	endfunction

	// Send whole scans of random length until target beams have gone,
	// retuning speed and threshold between some of them
	task automatic run_scans(input int unsigned target);
		int unsigned sent;
		int unsigned scan_len;
		int unsigned pick;
		logic [15:0] speed_q12;
		logic [15:0] limit_q8;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(1) == 1) begin
				pick = $urandom_range(99);
				if (pick < 15) begin
					speed_q12 = 16'h8000;
				end else if (pick < 25) begin
					speed_q12 = 16'h7FFF;
				end else if (pick < 35) begin
					speed_q12 = 16'h0000;
				end else if (pick < 40) begin
					speed_q12 = 16'hFFFF;
				end else if (pick < 45) begin
					speed_q12 = 16'h0001;
				end else if (pick < 75) begin
					// reversing: forward beams close in
					speed_q12 = 16'h8000 | 16'($urandom);
				end else begin
					speed_q12 = 16'($urandom);
				end
				pick = $urandom_range(99);
				if (pick < 10) begin
					limit_q8 = 16'h0000;
				end else if (pick < 20) begin
					limit_q8 = 16'hFFFF;
				end else if (pick < 30) begin
					limit_q8 = 16'd179;
				end else if (pick < 70) begin
					limit_q8 = 16'($urandom_range(4095));
				end else begin
					limit_q8 = 16'($urandom);
				end
				program_settings(speed_q12, limit_q8);
			end
			pick = $urandom_range(99);
			if (pick < 70) begin
				scan_len = $urandom_range(12, 1);
			end else if (pick < 95) begin
				scan_len = $urandom_range(60, 13);
			end else begin
				scan_len = $urandom_range(400, 61);
			end
			// trim the last scan so the total lands on target
			if (scan_len > target - sent) begin
				scan_len = target - sent;
			end
			for (int b = 0; b < scan_len; b++) begin
				send_beam(pick_range(), b == scan_len - 1);
			end
			sent += scan_len;
		end
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_item        = '0;
		out_ready      = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		send_idle_pct  = 38;
		sink_stall_pct = 55;
		repeat (RESET_CYCLES) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero speed saturates every beam, nothing brakes
		send_beam(16'd0, 1'b0);
		send_beam(16'hFFFF, 1'b1);

		// Full reverse speed with the highest threshold: zero range gives zero
		// time, every unsaturated beam brakes
		program_settings(16'h8000, 16'hFFFF);
		send_beam(16'd0, 1'b0);
		send_beam(16'hFFFF, 1'b0);
		send_beam(16'd1432, 1'b1);

		// Full forward speed opens the gap on the first beam; zero threshold
		program_settings(16'h7FFF, 16'h0000);
		send_beam(16'd1, 1'b1);

		// Smallest reverse speed: the quotient crosses its limit between 15 and 16
		program_settings(16'hFFFF, 16'd179);
		send_beam(16'd15, 1'b0);
		send_beam(16'd16, 1'b0);
		send_beam(16'hFFFF, 1'b1);

		// Reverse at 1 m/s against a one-second threshold: time equals range,
		// so the brake flag flips right at the threshold
		program_settings(16'hF000, 16'h0100);
		send_beam(16'd255, 1'b0);
		send_beam(16'd256, 1'b0);
		send_beam(16'd257, 1'b0);
		send_beam(16'h5555, 1'b0);
		send_beam(16'hAAAA, 1'b1);

		run_scans(180);
		send_idle_pct  = 55;
		sink_stall_pct = 38;
		run_scans(180);
		send_idle_pct  = 0;
		sink_stall_pct = 0;
		run_scans(180);

		wait_idle();
		repeat (SETTLE_CYCLES) begin
			@(posedge clk);
		end
		if (failures == 0 && beams_in_flight == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog: several times the slowest legal run
	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
